@@ hdl/assert_macros.svh @@
// assertion helpers, clocked on i_clk and disabled while i_rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge
`define AST_ALWAYS(label, expr) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("assertion failed: %m");

// antecedent at one edge implies consequent at the next edge
`define AST_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: %m");

// antecedent implies consequent at the same edge
`define AST_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: %m");

`endif

@@ hdl/jsu_pkg.sv @@
`default_nettype none

package jsu_pkg;

    typedef enum logic [1:0] {
        MODE_TEXT = 2'd0,
        MODE_ESC  = 2'd1,
        MODE_HEX  = 2'd2
    } t_mode;

    typedef struct packed {
        t_mode       mode;
        logic [1:0]  seen;
        logic [11:0] acc;
    } t_state;

    localparam t_state STATE_RESET = '{mode: MODE_TEXT, seen: 2'd0, acc: 12'd0};

    // decode result of one input byte: up to three output bytes
    typedef struct packed {
        logic [1:0]      cnt;
        logic [2:0][7:0] bytes;
        logic            bvalid;
        logic            incomplete;
        t_state          nxt;
    } t_dec;

endpackage

`default_nettype wire

@@ hdl/jsu_in_if.sv @@
`default_nettype none

interface jsu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_string;

    modport source (output valid, output in_byte, output end_of_string, input ready);
    modport sink (input valid, input in_byte, input end_of_string, output ready);
endinterface

`default_nettype wire

@@ hdl/jsu_out_if.sv @@
`default_nettype none

interface jsu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       run_last;
    logic       string_done;
    logic       incomplete_escape;

    modport source (
        output valid, output out_byte, output byte_valid, output run_last,
        output string_done, output incomplete_escape, input ready
    );
    modport sink (
        input valid, input out_byte, input byte_valid, input run_last,
        input string_done, input incomplete_escape, output ready
    );
endinterface

`default_nettype wire

@@ hdl/jsu_decode.sv @@
`default_nettype none

module jsu_decode import jsu_pkg::*; (
    input  t_state     i_state,
    input  logic [7:0] i_byte,
    input  logic       i_eos,
    output t_dec       o_dec
);

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_SLASH  = 8'h2f;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6e;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CC_BS     = 8'h08;
    localparam logic [7:0] CC_FF     = 8'h0c;
    localparam logic [7:0] CC_LF     = 8'h0a;
    localparam logic [7:0] CC_CR     = 8'h0d;
    localparam logic [7:0] CC_TAB    = 8'h09;
    localparam logic [7:0] LEAD2     = 8'hc0;
    localparam logic [7:0] LEAD3     = 8'he0;
    localparam logic [7:0] CONT      = 8'h80;
    localparam logic [7:0] UCASE     = 8'hdf;

    logic [7:0]  dig_diff;
    logic [3:0]  nib;
    logic [15:0] code;
    t_dec        d;

    // unchecked hex digit value, modulo 16
    always_comb begin
        if (i_byte <= 8'h39) begin
            dig_diff = i_byte - 8'h30;
        end else begin
            dig_diff = (i_byte & UCASE) - 8'h37;
        end
        nib  = dig_diff[3:0];
        code = {i_state.acc, nib};
    end

    always_comb begin
        d            = '0;
        d.bvalid     = 1'b1;
        d.nxt        = i_state;
        case (i_state.mode)
            MODE_ESC: begin
                d.nxt.mode = MODE_TEXT;
                d.cnt      = 2'd1;
                case (i_byte)
                    CH_QUOTE, CH_BSLASH, CH_SLASH: d.bytes[0] = i_byte;
                    CH_B: d.bytes[0] = CC_BS;
                    CH_F: d.bytes[0] = CC_FF;
                    CH_N: d.bytes[0] = CC_LF;
                    CH_R: d.bytes[0] = CC_CR;
                    CH_T: d.bytes[0] = CC_TAB;
                    CH_U: begin
                        d.cnt = 2'd0;
                        d.nxt = '{mode: MODE_HEX, seen: 2'd0, acc: 12'd0};
                    end
                    default: d.cnt = 2'd0;
                endcase
            end
            MODE_HEX: begin
                if (i_state.seen != 2'd3) begin
                    d.nxt.acc  = {i_state.acc[7:0], nib};
                    d.nxt.seen = i_state.seen + 2'd1;
                end else begin
                    d.nxt = STATE_RESET;
                    if (code[15:7] == '0) begin
                        d.cnt      = 2'd1;
                        d.bytes[0] = {1'b0, code[6:0]};
                    end else if (code[15:11] == '0) begin
                        d.cnt      = 2'd2;
                        d.bytes[0] = LEAD2 | {3'b000, code[10:6]};
                        d.bytes[1] = CONT | {2'b00, code[5:0]};
                    end else begin
                        d.cnt      = 2'd3;
                        d.bytes[0] = LEAD3 | {4'b0000, code[15:12]};
                        d.bytes[1] = CONT | {2'b00, code[11:6]};
                        d.bytes[2] = CONT | {2'b00, code[5:0]};
                    end
                end
            end
            default: begin
                if (i_byte == CH_BSLASH) begin
                    d.nxt.mode = MODE_ESC;
                end else begin
                    d.cnt      = 2'd1;
                    d.bytes[0] = i_byte;
                end
            end
        endcase

        // end of string: drop any partial escape, always emit at least one result
        if (i_eos) begin
            if (d.cnt == 2'd0) begin
                d.cnt        = 2'd1;
                d.bytes[0]   = 8'h00;
                d.bvalid     = 1'b0;
                d.incomplete = (d.nxt.mode == MODE_ESC) || (d.nxt.mode == MODE_HEX);
            end
            d.nxt = STATE_RESET;
        end
        o_dec = d;
    end

endmodule

`default_nettype wire

@@ hdl/json_string_unescape_utf8.sv @@
// pipeline: an input transfer is captured in the input register and decoded into the
//   result register, from which its first result can be taken
// throughput: one input per cycle, but an input giving results waits for a free result
//   register and holds it until all are taken (unicode escapes give up to three)
// reset: i_rst_n synchronous active low; clears both stages and returns to text mode
`default_nettype none

module json_string_unescape_utf8 import jsu_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    jsu_in_if.sink     i_in,
    jsu_out_if.source  o_out
);

    `include "assert_macros.svh"

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_eos;

    // escape decoder state
    t_state     r_state;

    // result register: holds every result of one input, walked by an index
    logic            r_res_busy;
    logic [1:0]      r_res_cnt;
    logic [1:0]      r_res_idx;
    logic [2:0][7:0] r_res_byte;
    logic            r_res_bvalid;
    logic            r_res_eos;
    logic            r_res_incomplete;

    t_dec       dec;
    logic       res_last;
    logic       out_take;
    logic       res_free;
    logic       adv;
    logic       load_res;
    logic [1:0] n_res_idx;

    jsu_decode u_decode (
        .i_state (r_state),
        .i_byte  (r_in_byte),
        .i_eos   (r_in_eos),
        .o_dec   (dec)
    );

    always_comb begin
        res_last  = (r_res_idx == (r_res_cnt - 2'd1));
        out_take  = r_res_busy && o_out.ready;
        // result register empties this cycle when its last result is taken
        res_free  = !r_res_busy || (out_take && res_last);
        // an input with no result never waits on the output side
        adv       = r_in_valid && ((dec.cnt == 2'd0) || res_free);
        load_res  = adv && (dec.cnt != 2'd0);
        n_res_idx = r_res_idx + 2'd1;
    end

    assign i_in.ready = !r_in_valid || adv;

    // output fields come straight from the result register
    assign o_out.valid             = r_res_busy;
    assign o_out.out_byte          = r_res_byte[r_res_idx];
    assign o_out.byte_valid        = r_res_bvalid;
    assign o_out.run_last          = res_last;
    assign o_out.string_done       = res_last && r_res_eos;
    assign o_out.incomplete_escape = r_res_incomplete;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_state    <= STATE_RESET;
            r_res_busy <= 1'b0;
            r_res_cnt  <= 2'd0;
            r_res_idx  <= 2'd0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (adv) begin
                r_state <= dec.nxt;
            end
            if (load_res) begin
                r_res_busy <= 1'b1;
                r_res_cnt  <= dec.cnt;
                r_res_idx  <= 2'd0;
            end else if (out_take && res_last) begin
                r_res_busy <= 1'b0;
            end else if (out_take) begin
                r_res_idx <= n_res_idx;
            end
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_byte <= i_in.in_byte;
            r_in_eos  <= i_in.end_of_string;
        end
        if (load_res) begin
            r_res_byte       <= dec.bytes;
            r_res_bvalid     <= dec.bvalid;
            r_res_eos        <= r_in_eos;
            r_res_incomplete <= dec.incomplete;
        end
    end

    // index walks only the loaded results
    `AST_SAME(a_idx_in_range, r_res_busy, (r_res_idx < r_res_cnt) && (r_res_cnt != 2'd0))
    // a result with no byte is only the lone end-of-string marker
    `AST_SAME(a_empty_is_eos, r_res_busy && !r_res_bvalid, r_res_eos && (r_res_cnt == 2'd1))
    // an unfinished escape is flagged only on a result with no byte
    `AST_SAME(a_incomplete_no_byte, r_res_busy && r_res_incomplete, !r_res_bvalid)
    // the end of a string returns the decoder to its reset state
    `AST_NEXT(a_eos_clears, adv && r_in_eos, r_state == STATE_RESET)

endmodule

`default_nettype wire

@@ test/tb_json_string_unescape_utf8.sv @@
`timescale 1ns / 100ps

module tb_json_string_unescape_utf8 import jsu_pkg::*; ();

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int LONG_HOLD    = 48;
    localparam int RANDOM_ITEMS = 300;

    // characters with a meaning inside a string body
    localparam logic [7:0] CH_BACKSLASH = 8'h5c;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_SLASH     = 8'h2f;
    localparam logic [7:0] CH_ESC_B     = 8'h62;
    localparam logic [7:0] CH_ESC_F     = 8'h66;
    localparam logic [7:0] CH_ESC_N     = 8'h6e;
    localparam logic [7:0] CH_ESC_R     = 8'h72;
    localparam logic [7:0] CH_ESC_T     = 8'h74;
    localparam logic [7:0] CH_ESC_U     = 8'h75;
    localparam logic [7:0] CH_UNKNOWN   = 8'h78;

    // control codes the short escapes stand for
    localparam logic [7:0] CTL_BACKSPACE = 8'h08;
    localparam logic [7:0] CTL_FORMFEED  = 8'h0c;
    localparam logic [7:0] CTL_NEWLINE   = 8'h0a;
    localparam logic [7:0] CTL_RETURN    = 8'h0d;
    localparam logic [7:0] CTL_TAB       = 8'h09;

    // hex digit decode and utf-8 framing
    localparam logic [7:0] DIGIT_ZERO = 8'h30;
    localparam logic [7:0] DIGIT_NINE = 8'h39;
    localparam logic [7:0] CASE_MASK  = 8'hdf;
    localparam logic [7:0] ALPHA_BIAS = 8'h37;
    localparam logic [7:0] UPPER_A    = 8'h41;
    localparam logic [7:0] LOWER_A    = 8'h61;
    localparam logic [7:0] UTF8_LEAD2 = 8'hc0;
    localparam logic [7:0] UTF8_LEAD3 = 8'he0;
    localparam logic [7:0] UTF8_CONT  = 8'h80;

    // one output transfer as the block should present it
    typedef struct packed {
        logic [7:0] data;
        logic       has_byte;
        logic       run_end;
        logic       str_end;
        logic       cut_escape;
    } t_beat;

    logic i_clk = 1'b0;
    logic i_rst_n;

    jsu_in_if  in_ch ();
    jsu_out_if out_ch ();

    json_string_unescape_utf8 u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // decoder state mirrored on the testbench side
    t_mode       esc_mode  = MODE_TEXT;
    logic [1:0]  hex_count = 2'd0;
    logic [11:0] hex_acc   = 12'd0;

    t_beat      pending_decoded[$];   // decoded bytes still owed by the block
    logic [7:0] str_bytes[$];         // body of the string being assembled

    bit idle_on   = 1'b0;
    int sink_wait = 0;
    int hold_off  = 0;
    int errors    = 0;
    int cycles    = 0;
    int items_sent      = 0;
    int strings_sent    = 0;
    int results_checked = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // prediction: decode one accepted input byte into the expected beats
    // ------------------------------------------------------------------
    task automatic unescape_step(input logic [7:0] b, input logic eos);
        logic [7:0]  emit[$];
        logic [7:0]  tmp;
        logic [3:0]  nib;
        logic [15:0] cp;
        logic        cut;
        t_beat       one;
        cut = 1'b0;
        case (esc_mode)
            MODE_ESC: begin
                esc_mode = MODE_TEXT;
                case (b)
                    CH_QUOTE, CH_BACKSLASH, CH_SLASH: emit = {emit, b};
                    CH_ESC_B: emit = {emit, CTL_BACKSPACE};
                    CH_ESC_F: emit = {emit, CTL_FORMFEED};
                    CH_ESC_N: emit = {emit, CTL_NEWLINE};
                    CH_ESC_R: emit = {emit, CTL_RETURN};
                    CH_ESC_T: emit = {emit, CTL_TAB};
                    CH_ESC_U: begin
                        esc_mode  = MODE_HEX;
                        hex_count = 2'd0;
                        hex_acc   = 12'd0;
                    end
                    default: ;   // unknown escape swallows both bytes
                endcase
            end
            MODE_HEX: begin
                // digits are never validated, only the low nibble counts
                if (b <= DIGIT_NINE)
                    tmp = b - DIGIT_ZERO;
                else
                    tmp = (b & CASE_MASK) - ALPHA_BIAS;
                nib = tmp[3:0];
                if (hex_count < 2'd3) begin
                    hex_acc   = {hex_acc[7:0], nib};
                    hex_count = hex_count + 2'd1;
                end else begin
                    cp = {hex_acc, nib};
                    if (cp < 16'h0080) begin
                        emit = {emit, cp[7:0]};
                    end else if (cp < 16'h0800) begin
                        emit = {emit, UTF8_LEAD2 + {3'b0, cp[10:6]}};
                        emit = {emit, UTF8_CONT + {2'b0, cp[5:0]}};
                    end else begin
                        emit = {emit, UTF8_LEAD3 + {4'b0, cp[15:12]}};
                        emit = {emit, UTF8_CONT + {2'b0, cp[11:6]}};
                        emit = {emit, UTF8_CONT + {2'b0, cp[5:0]}};
                    end
                    esc_mode  = MODE_TEXT;
                    hex_count = 2'd0;
                    hex_acc   = 12'd0;
                end
            end
            default: begin
                // the unused mode value behaves as text
                if (b == CH_BACKSLASH)
                    esc_mode = MODE_ESC;
                else
                    emit = {emit, b};
            end
        endcase

        // end of string drops any partial escape and returns to text mode
        if (eos) begin
            cut       = (esc_mode == MODE_ESC) || (esc_mode == MODE_HEX);
            esc_mode  = MODE_TEXT;
            hex_count = 2'd0;
            hex_acc   = 12'd0;
        end

        // a string end that produced nothing still gets one empty beat
        if (eos && emit.size() == 0) begin
            one            = '0;
            one.run_end    = 1'b1;
            one.str_end    = 1'b1;
            one.cut_escape = cut;
            pending_decoded = {pending_decoded, one};
        end
        foreach (emit[i]) begin
            one          = '0;
            one.data     = emit[i];
            one.has_byte = 1'b1;
            one.run_end  = (i == emit.size() - 1);
            one.str_end  = eos && (i == emit.size() - 1);
            pending_decoded = {pending_decoded, one};
        end
    endtask

    // ------------------------------------------------------------------
    // input side: gap, offer, wait for the transfer, then predict
    // ------------------------------------------------------------------
    task automatic send_item(input logic [7:0] b, input logic eos);
        int gap;
        gap = idle_on ? $urandom_range(0, 3) : 0;
        repeat (gap) begin
            @(negedge i_clk);
            in_ch.valid = 1'b0;
        end
        @(negedge i_clk);
        in_ch.valid         = 1'b1;
        in_ch.in_byte       = b;
        in_ch.end_of_string = eos;
        do @(posedge i_clk); while (!in_ch.ready);
        unescape_step(b, eos);
        items_sent++;
    endtask

    // sends the assembled body, end_of_string on its last byte
    task automatic send_string();
        int n;
        n = str_bytes.size();
        for (int i = 0; i < n; i++)
            send_item(str_bytes[i], i == n - 1);
        str_bytes.delete();
        strings_sent++;
    endtask

    // drop valid and hold off until every owed byte has come out
    task automatic wait_drained();
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        while (pending_decoded.size() != 0)
            @(posedge i_clk);
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10)
            return DIGIT_ZERO + {4'b0, n};
        return ($urandom_range(0, 1) ? UPPER_A : LOWER_A) + {4'b0, n - 4'd10};
    endfunction

    // appends one byte to the string being assembled
    task automatic add_byte(input logic [7:0] ch);
        str_bytes = {str_bytes, ch};
    endtask

    task automatic put_escape(input logic [7:0] ch);
        add_byte(CH_BACKSLASH);
        add_byte(ch);
    endtask

    // \u escape with four well-formed digits in mixed case
    task automatic put_unicode(input logic [15:0] code);
        put_escape(CH_ESC_U);
        for (int k = 3; k >= 0; k--)
            add_byte(hex_char(code[4*k +: 4]));
    endtask

    task automatic put_random_token();
        logic [15:0] code;
        logic [7:0]  rnd;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                // plain byte, a stray backslash here opens an escape too
                rnd = 8'($urandom_range(0, 255));
                add_byte(rnd);
            end
            4: begin
                case ($urandom_range(0, 7))
                    0: put_escape(CH_QUOTE);
                    1: put_escape(CH_BACKSLASH);
                    2: put_escape(CH_SLASH);
                    3: put_escape(CH_ESC_B);
                    4: put_escape(CH_ESC_F);
                    5: put_escape(CH_ESC_N);
                    6: put_escape(CH_ESC_R);
                    default: put_escape(CH_ESC_T);
                endcase
            end
            5: begin
                // any byte after a backslash, mostly unknown escapes
                rnd = 8'($urandom_range(0, 255));
                put_escape(rnd);
            end
            6, 7, 8: begin
                case ($urandom_range(0, 4))
                    0: code = 16'($urandom_range(0, 16'h007f));
                    1: code = 16'($urandom_range(16'h0080, 16'h07ff));
                    2: code = 16'($urandom_range(16'h0800, 16'hffff));
                    3: begin
                        // utf-8 length boundaries
                        case ($urandom_range(0, 5))
                            0: code = 16'h0000;
                            1: code = 16'h007f;
                            2: code = 16'h0080;
                            3: code = 16'h07ff;
                            4: code = 16'h0800;
                            default: code = 16'hffff;
                        endcase
                    end
                    default: code = 16'($urandom_range(0, 16'hffff));
                endcase
                put_unicode(code);
            end
            default: begin
                // \u followed by arbitrary bytes as digits
                put_escape(CH_ESC_U);
                repeat (4) begin
                    rnd = 8'($urandom_range(0, 255));
                    add_byte(rnd);
                end
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // output side: ready pattern and result checking
    // ------------------------------------------------------------------

    // a long hold-off overrides the per-transfer random stall
    always @(negedge i_clk) begin
        if (hold_off > 0) begin
            out_ch.ready = 1'b0;
            hold_off--;
        end else if (sink_wait > 0) begin
            out_ch.ready = 1'b0;
            sink_wait--;
        end else begin
            out_ch.ready = 1'b1;
        end
    end

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
            errors++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_beat want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_decoded.size() == 0) begin
                $display("%0t: unexpected transfer: expected none, got byte %0h valid %b",
                         $time, out_ch.out_byte, out_ch.byte_valid);
                errors++;
            end else begin
                want = pending_decoded.pop_front();
                check_field("out_byte", want.data, out_ch.out_byte);
                check_field("byte_valid", {7'b0, want.has_byte}, {7'b0, out_ch.byte_valid});
                check_field("run_last", {7'b0, want.run_end}, {7'b0, out_ch.run_last});
                check_field("string_done", {7'b0, want.str_end}, {7'b0, out_ch.string_done});
                check_field("incomplete_escape", {7'b0, want.cut_escape},
                            {7'b0, out_ch.incomplete_escape});
                results_checked++;
            end
            sink_wait = idle_on ? $urandom_range(0, 3) : 0;
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d results outstanding",
                     $time, cycles, pending_decoded.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // byte extremes pass straight through, no idling on either side
    task automatic test_plain_bytes();
        idle_on = 1'b0;
        add_byte(8'h00);
        add_byte(8'hff);
        send_string();
        wait_drained();
    endtask

    // every short escape, then an unknown one so the string ends with no byte
    task automatic test_simple_escapes();
        idle_on = 1'b1;
        put_escape(CH_QUOTE);
        put_escape(CH_BACKSLASH);
        put_escape(CH_SLASH);
        put_escape(CH_ESC_B);
        put_escape(CH_ESC_F);
        put_escape(CH_ESC_N);
        put_escape(CH_ESC_R);
        put_escape(CH_ESC_T);
        put_escape(CH_UNKNOWN);
        send_string();
        wait_drained();
    endtask

    // top code point, three utf-8 bytes out of a single input
    task automatic test_unicode_escape();
        idle_on = 1'b1;
        put_unicode(16'hffff);
        send_string();
        wait_drained();
    endtask

    // string cut right after a backslash, then in the middle of the digits
    task automatic test_unfinished_escapes();
        idle_on = 1'b1;
        add_byte(CH_BACKSLASH);
        send_string();
        put_unicode(16'h1234);
        repeat (2) void'(str_bytes.pop_back());
        send_string();
        wait_drained();
    endtask

    // receiver stops for a long stretch while the sender keeps offering
    task automatic test_backpressure();
        idle_on  = 1'b0;
        hold_off = LONG_HOLD;
        put_unicode(16'h20ac);
        put_unicode(16'hffff);
        put_unicode(16'h0800);
        add_byte(8'h41);
        put_unicode(16'h07ff);
        put_unicode(16'hd83d);
        send_string();
        wait_drained();
    endtask

    task automatic test_random_strings();
        int first_item;
        int keep;
        first_item = items_sent;
        while (items_sent - first_item < RANDOM_ITEMS) begin
            idle_on = ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(1, 8)) put_random_token();
            // some strings end early, usually inside an escape
            if ($urandom_range(0, 5) == 0) begin
                keep = $urandom_range(1, str_bytes.size());
                while (str_bytes.size() > keep)
                    void'(str_bytes.pop_back());
            end
            if ($urandom_range(0, 30) == 0)
                hold_off = LONG_HOLD;
            send_string();
            if ($urandom_range(0, 15) == 0)
                wait_drained();
        end
        wait_drained();
    endtask

    initial begin
        in_ch.valid         = 1'b0;
        in_ch.in_byte       = 8'h00;
        in_ch.end_of_string = 1'b0;
        out_ch.ready        = 1'b0;
        i_rst_n             = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_plain_bytes();
        test_simple_escapes();
        test_unicode_escape();
        test_unfinished_escapes();
        test_backpressure();
        test_random_strings();

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d strings, %0d input bytes sent, %0d output transfers checked",
                 strings_sent, items_sent, results_checked);
        $display("plain bytes, short/unknown/unicode escapes, cut strings, long stalls");
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/jsu_pkg.sv
hdl/jsu_in_if.sv
hdl/jsu_out_if.sv
hdl/jsu_decode.sv
hdl/json_string_unescape_utf8.sv
test/tb_json_string_unescape_utf8.sv
